/* rtl/grouped_max_min_tracker_unit_macros.svh */
// Assertion macros shared by the tracker RTL.
`ifndef GROUPED_MAX_MIN_TRACKER_UNIT_MACROS_SVH
`define GROUPED_MAX_MIN_TRACKER_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define GMT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition checked on the clock edge after the antecedent.
`define GMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gmmt_pkg.sv */
// Package with the types, codes and sizes of the grouped maximum tracker.
`default_nettype none
package gmmt_pkg;
  localparam int unsigned DefMaxElements = 1024;
  localparam int unsigned DefMaxGroups   = 256;
  localparam int unsigned IdW    = 10;
  localparam int unsigned ValW   = 32;
  localparam int unsigned GrpInW = 8;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_PRESENT = 2'd2
  } status_e;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_CHECK, S_SCAN_E, S_SCAN_E_END, S_PUT_RD, S_PUT_WR,
    S_SCAN_G, S_SCAN_G_END, S_OUT
  } state_e;
endpackage
`default_nettype wire

/* rtl/grouped_max_min_tracker_unit.sv */
// Top level of the grouped maximum tracker with its element and group memories.
//
// Each item adds or moves an element; after it the block returns the smallest
// maximum over all non-empty groups. Items are handled one at a time by a
// sequencer around the element memory and the group memory, both with a
// registered read port. The time from acceptance to result of an add is set by
// the sweep over the group memory for the minimum; a move adds a sweep over the
// element memory. A rejected item still takes the group sweep. The input is
// held off while a result waits, so the next item is taken only after the
// receiver has accepted the result. After reset a clearing pass sweeps both
// memories to zero before the first item is taken.
`default_nettype none
`include "grouped_max_min_tracker_unit_macros.svh"
module grouped_max_min_tracker_unit
  import gmmt_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = DefMaxElements,
  parameter int unsigned MAX_GROUPS   = DefMaxGroups
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // elem_id[9:0], value[41:10], group[49:42], zero
  input  wire logic        s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // min_of_max[31:0], none_nonempty[32], status[34:33]
);
  localparam int unsigned EAW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned GAW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned CW  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned NW  = ((EAW > GAW) ? EAW : GAW) + 1;
  localparam int unsigned ClrN = (MAX_ELEMENTS > MAX_GROUPS) ? MAX_ELEMENTS : MAX_GROUPS;
  localparam int unsigned EW  = ValW + GAW + 1;
  localparam int unsigned GW  = ValW + CW;

  // Element memory: {valid, group, value}; group memory: {count, max}.
  logic [EW-1:0] emem [MAX_ELEMENTS];
  logic [GW-1:0] gmem [MAX_GROUPS];
  logic [EW-1:0] e_rd_q;
  logic [GW-1:0] g_rd_q;
  logic          e_we, g_we;
  logic [EAW-1:0] e_wa, e_ra;
  logic [GAW-1:0] g_wa, g_ra;
  logic [EW-1:0] e_wd;
  logic [GW-1:0] g_wd;

  always_ff @(posedge clk_i) begin
    if (e_we) emem[e_wa] <= e_wd;
    e_rd_q <= emem[e_ra];
  end
  always_ff @(posedge clk_i) begin
    if (g_we) gmem[g_wa] <= g_wd;
    g_rd_q <= gmem[g_ra];
  end

  state_e state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          cmd_q;
  logic [EAW-1:0] id_q;
  logic [ValW-1:0] val_q, val_d;
  logic [GAW-1:0] dst_q, old_q, old_d;
  logic [ValW-1:0] best_q, best_d;
  logic          any_q, any_d;
  logic [1:0]    status_q, status_d;
  logic          ovalid_q, ovalid_d;
  logic [ValW-1:0] omin_q, omin_d;
  logic          onone_q, onone_d;
  logic [1:0]    ost_q, ost_d;

  logic [IdW-1:0]    in_id;
  logic [GrpInW-1:0] in_grp;
  assign in_id  = s_axis_tdata[IdW-1:0];
  assign in_grp = s_axis_tdata[IdW+ValW +: GrpInW];

  logic [EAW-1:0] in_e;
  logic [GAW-1:0] in_g;
  assign in_e = EAW'(32'(in_id) % MAX_ELEMENTS);
  assign in_g = GAW'(32'(in_grp) % MAX_GROUPS);

  logic          e_valid;
  logic [GAW-1:0] e_grp;
  logic [ValW-1:0] e_val;
  assign e_valid = e_rd_q[EW-1];
  assign e_grp   = e_rd_q[ValW +: GAW];
  assign e_val   = e_rd_q[ValW-1:0];
  logic [CW-1:0]  g_cnt;
  logic [ValW-1:0] g_max;
  assign g_cnt = g_rd_q[ValW +: CW];
  assign g_max = g_rd_q[ValW-1:0];

  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'd0, ost_q, onone_q, omin_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tuser;
      id_q  <= in_e;
      dst_q <= in_g;
    end
    val_q    <= val_d;
    old_q    <= old_d;
    best_q   <= best_d;
    any_q    <= any_d;
    status_q <= status_d;
    omin_q   <= omin_d;
    onone_q  <= onone_d;
    ost_q    <= ost_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    val_d = val_q;
    old_d = old_q;
    best_d = best_q;
    any_d = any_q;
    status_d = status_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    omin_d = omin_q;
    onone_d = onone_q;
    ost_d = ost_q;
    e_we = 1'b0; e_wa = id_q; e_wd = {1'b0, old_q, val_q}; e_ra = id_q;
    g_we = 1'b0; g_wa = old_q; g_wd = '0; g_ra = old_q;
    unique case (state_q)
      S_CLEAR: begin
        // Both memories are swept to zero after reset.
        e_we = (32'(cnt_q) < MAX_ELEMENTS);
        e_wa = cnt_q[EAW-1:0];
        e_wd = '0;
        g_we = (32'(cnt_q) < MAX_GROUPS);
        g_wa = cnt_q[GAW-1:0];
        g_wd = '0;
        if (32'(cnt_q) == ClrN - 1) begin
          cnt_d = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        e_ra = in_e;
        if (s_axis_tvalid && s_axis_tready) begin
          val_d = s_axis_tdata[IdW +: ValW];
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        status_d = ST_OK;
        if (cmd_q == CMD_ADD) begin
          if (e_valid) begin
            status_d = ST_PRESENT;
            state_d = S_SCAN_G;
            cnt_d = '0;
          end else begin
            old_d = dst_q;
            state_d = S_PUT_RD;
          end
        end else if (!e_valid) begin
          status_d = ST_UNKNOWN;
          state_d = S_SCAN_G;
          cnt_d = '0;
        end else begin
          // Drop the element, then rescan its old group for the new maximum.
          val_d = e_val;
          old_d = e_grp;
          e_we = 1'b1;
          e_wd = {1'b0, e_grp, e_val};
          any_d = 1'b0;
          best_d = '0;
          cnt_d = '0;
          state_d = S_SCAN_E;
        end
      end
      S_SCAN_E: begin
        e_ra = cnt_q[EAW-1:0];
        if (cnt_q != '0 && e_valid && e_grp == old_q) begin
          if (!any_q || e_val > best_q) best_d = e_val;
          any_d = 1'b1;
        end
        if (32'(cnt_q) == MAX_ELEMENTS - 1) state_d = S_SCAN_E_END;
        cnt_d = cnt_q + 1'b1;
      end
      S_SCAN_E_END: begin
        // Last element read lands now; group entry read is issued.
        if (e_valid && e_grp == old_q) begin
          if (!any_q || e_val > best_q) best_d = e_val;
          any_d = 1'b1;
        end
        state_d = S_PUT_WR;
        cnt_d = '0;
      end
      S_PUT_WR: begin
        // Old group: count down, new maximum from the scan.
        g_we = 1'b1;
        g_wd = {((g_cnt != '0) ? g_cnt - 1'b1 : g_cnt), (any_q ? best_q : '0)};
        old_d = dst_q;
        state_d = S_PUT_RD;
      end
      S_PUT_RD: begin
        g_ra = old_q;
        state_d = S_OUT;
        cnt_d = '0;
      end
      S_OUT: begin
        // Insert into the destination group and restart the group sweep.
        g_we = 1'b1;
        g_wd = {g_cnt + 1'b1, ((g_cnt == '0 || val_q > g_max) ? val_q : g_max)};
        e_we = 1'b1;
        e_wd = {1'b1, dst_q, val_q};
        state_d = S_SCAN_G;
        cnt_d = '0;
      end
      S_SCAN_G: begin
        g_ra = cnt_q[GAW-1:0];
        if (cnt_q == '0) begin
          any_d = 1'b0;
          best_d = '0;
        end else if (g_cnt != '0) begin
          if (!any_q || g_max < best_q) best_d = g_max;
          any_d = 1'b1;
        end
        if (32'(cnt_q) == MAX_GROUPS - 1) state_d = S_SCAN_G_END;
        cnt_d = cnt_q + 1'b1;
      end
      S_SCAN_G_END: begin
        if (!ovalid_d) begin
          omin_d = best_q;
          onone_d = !any_q;
          if (g_cnt != '0) begin
            omin_d = (!any_q || g_max < best_q) ? g_max : best_q;
            onone_d = 1'b0;
          end
          ost_d = status_q;
          ovalid_d = 1'b1;
          cnt_d = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `GMT_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
    state_q == S_IDLE && !ovalid_q, "item accepted while busy")
  `GMT_ASSERT_NEXT(a_accept_look, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
    state_q == S_LOOK, "accepted item did not start lookup")
  `GMT_ASSERT_IMPL(a_none_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[32],
    m_axis_tdata[31:0] == '0, "empty result with non-zero minimum")
  `GMT_ASSERT_IMPL(a_status_code, clk_i, rst_ni, m_axis_tvalid,
    m_axis_tdata[34:33] != 2'd3, "invalid status")
endmodule
`default_nettype wire

/* tb/gmmt_checker.sv */
// Checker that predicts and compares the results of the grouped maximum tracker.
module gmmt_checker
  import gmmt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // elem_id[9:0], value[41:10], group[49:42], zero
  input  wire logic        s_axis_tuser,  // cmd
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [39:0] m_axis_tdata,  // min_of_max[31:0], none_nonempty[32], status[34:33]
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [31:0] min_of_max;
    logic        none_nonempty;
    status_e     status;
  } tracker_result_t;

  logic [31:0]     elem_val [DefMaxElements];
  logic [7:0]      elem_grp [DefMaxElements];
  logic            elem_live[DefMaxElements];
  logic [31:0]     grp_max  [DefMaxGroups];
  int unsigned     grp_cnt  [DefMaxGroups];
  tracker_result_t expected_min_q[$];

  initial begin
    fail_count_o = 0;
    for (int k = 0; k < DefMaxElements; k++) begin
      elem_val[k]  = '0;
      elem_grp[k]  = '0;
      elem_live[k] = 1'b0;
    end
    for (int k = 0; k < DefMaxGroups; k++) begin
      grp_max[k] = '0;
      grp_cnt[k] = 0;
    end
  end

  assign pending_o = expected_min_q.size();

  task automatic join_group(input logic [9:0] id, input logic [7:0] grp);
    elem_grp[id]  = grp;
    elem_live[id] = 1'b1;
    if (grp_cnt[grp] == 0 || elem_val[id] > grp_max[grp]) grp_max[grp] = elem_val[id];
    grp_cnt[grp]++;
  endtask

  // Leaving a group rescans its remaining members for the new maximum.
  task automatic leave_group(input logic [9:0] id);
    logic [7:0]  grp;
    logic [31:0] best;
    grp           = elem_grp[id];
    best          = '0;
    elem_live[id] = 1'b0;
    if (grp_cnt[grp] > 0) grp_cnt[grp]--;
    for (int k = 0; k < DefMaxElements; k++)
      if (elem_live[k] && elem_grp[k] == grp && elem_val[k] > best) best = elem_val[k];
    grp_max[grp] = best;
  endtask

  task automatic predict_min_of_max(input logic cmd, input logic [9:0] id,
                                    input logic [31:0] val, input logic [7:0] grp);
    tracker_result_t res;
    logic            any;
    res.status = ST_OK;
    any        = 1'b0;
    res.min_of_max = '0;
    if (cmd == CMD_ADD) begin
      if (elem_live[id]) res.status = ST_PRESENT;
      else begin
        elem_val[id] = val;
        join_group(id, grp);
      end
    end else begin
      if (!elem_live[id]) res.status = ST_UNKNOWN;
      else begin
        leave_group(id);
        join_group(id, grp);
      end
    end
    for (int k = 0; k < DefMaxGroups; k++)
      if (grp_cnt[k] > 0) begin
        if (!any || grp_max[k] < res.min_of_max) res.min_of_max = grp_max[k];
        any = 1'b1;
      end
    res.none_nonempty = !any;
    expected_min_q.push_back(res);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      predict_min_of_max(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[41:10],
                         s_axis_tdata[49:42]);
  end

  always @(posedge clk_i) begin
    tracker_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_min_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        fail_count_o++;
      end else begin
        want = expected_min_q.pop_front();
        if (m_axis_tdata[31:0] !== want.min_of_max) begin
          $display("%0t: min_of_max expected %h actual %h", $time, want.min_of_max,
                   m_axis_tdata[31:0]);
          fail_count_o++;
        end
        if (m_axis_tdata[32] !== want.none_nonempty) begin
          $display("%0t: none_nonempty expected %b actual %b", $time, want.none_nonempty,
                   m_axis_tdata[32]);
          fail_count_o++;
        end
        if (m_axis_tdata[34:33] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   m_axis_tdata[34:33]);
          fail_count_o++;
        end
      end
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the tracker testbench: stimulus, receiver back-pressure and verdict.
module testbench;
  import gmmt_pkg::*;

  localparam int IdleLimit = 30000;
  localparam int Settle    = 1500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          items_sent = 0;
  int          idle_cycles = 0;
  logic        quiet_tail = 1'b0;
  logic        hold_req = 1'b0;
  logic        live_id[DefMaxElements];
  int          live_count = 0;

  always #1 clk_i = ~clk_i;

  grouped_max_min_tracker_unit u_dut (.*);

  gmmt_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Sends one item after an optional idle burst and waits until it is taken.
  task automatic send_item(input logic cmd, input logic [9:0] id,
                           input logic [31:0] val, input logic [7:0] grp);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'b0, grp, val, id};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (cmd == CMD_ADD && !live_id[id]) begin
      live_id[id] = 1'b1;
      live_count++;
    end
  endtask

  function automatic logic [9:0] pick_live();
    logic [9:0] id;
    do id = $urandom_range(0, 1023); while (!live_id[id]);
    return id;
  endfunction

  function automatic logic [9:0] pick_free();
    logic [9:0] id;
    do id = $urandom_range(0, 1023); while (live_id[id]);
    return id;
  endfunction

  // Receiver: random stall bursts, one long hold-off on request, none at the tail.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (4000) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int         r;
    logic [7:0] grp;
    logic [31:0] val;
    for (int k = 0; k < DefMaxElements; k++) live_id[k] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, both commands and every rejected case.
    send_item(CMD_MOVE, 10'd5, 32'h0, 8'd3);
    send_item(CMD_ADD, 10'd0, 32'h0, 8'd0);
    send_item(CMD_ADD, 10'd0, 32'hFFFF_FFFF, 8'd7);
    send_item(CMD_ADD, 10'd1023, 32'hFFFF_FFFF, 8'd255);
    send_item(CMD_MOVE, 10'd0, 32'hFFFF_FFFF, 8'd255);
    send_item(CMD_MOVE, 10'd0, 32'h1234_5678, 8'd255);
    send_item(CMD_ADD, 10'd2, 32'h5, 8'd1);
    send_item(CMD_ADD, 10'd3, 32'h5, 8'd1);
    send_item(CMD_MOVE, 10'd1023, 32'h0, 8'd1);
    send_item(CMD_MOVE, 10'd2, 32'hAAAA_5555, 8'd0);
    send_item(CMD_MOVE, 10'd1023, 32'h5555_AAAA, 8'd0);
    send_item(CMD_ADD, 10'd512, 32'h8000_0000, 8'd128);
    send_item(CMD_MOVE, 10'd1000, 32'h0, 8'd0);
    send_item(CMD_ADD, 10'd1023, 32'h0, 8'd2);

    for (int n = 0; n < 460; n++) begin
      if (n == 100) hold_req = 1'b1;
      if (n == 400) quiet_tail = 1'b1;
      r   = $urandom_range(0, 99);
      grp = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      val = ($urandom_range(0, 1)) ? 32'($urandom_range(0, 15)) : $urandom;
      if (r < 20 || live_count < 4) send_item(CMD_ADD, pick_free(), val, grp);
      else if (r < 85) send_item(CMD_MOVE, pick_live(), val, grp);
      else if (r < 92) send_item(CMD_MOVE, pick_free(), val, grp);
      else send_item(CMD_ADD, pick_live(), val, grp);
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
